FILE: sv/ctlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlm_pkg: shared definitions for the cohort ticket lock manager
// Field widths, operation codes, result status codes and register map.
// ----------------------------------------------------------------------------
package ctlm_pkg;

	// Item field widths
	localparam int OpcodeW = 3;
	localparam int NodeW   = 2;
	localparam int TicketW = 8;
	localparam int StatusW = 3;

	// Configuration port
	localparam int PaddrW = 3;
	localparam int PdataW = 32;
	localparam int LimitW = 8;
	localparam int BudgetW = 9;

	typedef logic [OpcodeW-1:0] opcode_t;
	typedef logic [StatusW-1:0] status_t;

	// Operation codes
	localparam opcode_t OP_TAKE_LOCAL  = 3'd0;
	localparam opcode_t OP_POLL_LOCAL  = 3'd1;
	localparam opcode_t OP_TAKE_GLOBAL = 3'd2;
	localparam opcode_t OP_POLL_GLOBAL = 3'd3;
	localparam opcode_t OP_TRYLOCK     = 3'd4;
	localparam opcode_t OP_UNLOCK      = 3'd5;

	// Result status codes
	localparam status_t ST_ISSUED      = 3'd0;
	localparam status_t ST_WAIT        = 3'd1;
	localparam status_t ST_ACQUIRED    = 3'd2;
	localparam status_t ST_NEED_GLOBAL = 3'd3;
	localparam status_t ST_BUSY        = 3'd4;
	localparam status_t ST_PASSED      = 3'd5;
	localparam status_t ST_RELEASED    = 3'd6;

	// Register word indexes (word index is paddr[2])
	localparam logic REG_BATCH_LIMIT = 1'b0;

	localparam logic [LimitW-1:0] BatchLimitReset = 8'd64;

endpackage

FILE: sv/ctlm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlm_req_if / ctlm_rsp_if: valid/ready item channels
// Request channel carries one lock operation; response channel one result.
// ----------------------------------------------------------------------------
interface ctlm_req_if;
	logic                                valid;
	logic                                ready;
	logic [ctlm_pkg::OpcodeW-1:0]        opcode;
	logic [ctlm_pkg::NodeW-1:0]          node;
	logic [ctlm_pkg::TicketW-1:0]        ticket;

	modport source (output valid, output opcode, output node, output ticket, input ready);
	modport sink   (input valid, input opcode, input node, input ticket, output ready);
endinterface

interface ctlm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [ctlm_pkg::StatusW-1:0]        status;
	logic [ctlm_pkg::TicketW-1:0]        ticket_out;

	modport source (output valid, output status, output ticket_out, input ready);
	modport sink   (input valid, input status, input ticket_out, output ready);
endinterface

FILE: sv/cohort_ticket_lock_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cohort_ticket_lock_manager_top: NUMA cohort lock, per-node and global tickets
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless the result stalls; the per-node
// counter update is a single read-modify-write from input to result register.
// Reset (arst_n low, asynchronous): all counters, pass flags, budgets and the
// holder clear to zero, batch_limit returns to 64, both channels go empty.
// ----------------------------------------------------------------------------
module cohort_ticket_lock_manager_top #(
	parameter int NODES       = 4,
	parameter int TICKET_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ctlm_req_if.sink                          req,
	ctlm_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ctlm_pkg::PaddrW-1:0]       paddr,
	input  logic [ctlm_pkg::PdataW-1:0]       pwdata,
	output logic [ctlm_pkg::PdataW-1:0]       prdata,
	output logic                              pready
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int TB = TICKET_BITS;
	localparam int TW = ctlm_pkg::TicketW;
	localparam int BW = ctlm_pkg::BudgetW;

	typedef logic [TB-1:0] tick_t;
	typedef logic [NW-1:0] nidx_t;

	// Lock state
	tick_t                         local_next_q    [NODES];
	tick_t                         local_serving_q [NODES];
	logic                          cohort_pass_q   [NODES];
	logic [BW-1:0]                 batch_left_q    [NODES];
	tick_t                         global_next_q;
	tick_t                         global_serving_q;
	logic [ctlm_pkg::NodeW-1:0]    holder_node_q;
	logic [ctlm_pkg::LimitW-1:0]   batch_limit_q;

	// Input register
	logic                          valid_s1;
	ctlm_pkg::opcode_t             opcode_s1;
	logic [ctlm_pkg::NodeW-1:0]    node_s1;
	logic [TW-1:0]                 ticket_s1;

	// Result register
	logic                          out_valid_q;
	ctlm_pkg::status_t             status_q;
	logic [TW-1:0]                 ticket_out_q;

	logic                          advance;
	logic                          fire;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ctlm_pkg::REG_BATCH_LIMIT) ?
		ctlm_pkg::PdataW'(batch_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_limit_q <= ctlm_pkg::BatchLimitReset;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == ctlm_pkg::REG_BATCH_LIMIT)) begin
			batch_limit_q <= pwdata[ctlm_pkg::LimitW-1:0];
		end
	end

	// Handshake: the input stage moves on whenever the result register is free
	assign advance   = !out_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			opcode_s1 <= req.opcode;
			node_s1   <= req.node;
			ticket_s1 <= req.ticket;
		end
	end

	// Index and operand selection
	logic [NW+1:0]   node_ext;
	logic [NW+1:0]   hold_ext;
	logic [TB+7:0]   tk_ext;
	logic            node_ok;
	nidx_t           hidx;
	nidx_t           aidx;
	tick_t           tk;
	tick_t           ln;
	tick_t           ls;
	logic            cp;
	logic [BW-1:0]   bl;

	assign node_ext = {NW'(0), node_s1};
	assign hold_ext = {NW'(0), holder_node_q};
	assign tk_ext   = {TB'(0), ticket_s1};
	assign tk       = tk_ext[TB-1:0];
	assign node_ok  = (32'(node_s1) < 32'(NODES));
	assign hidx     = (32'(holder_node_q) < 32'(NODES)) ? hold_ext[NW-1:0] : '0;
	assign aidx     = (opcode_s1 == ctlm_pkg::OP_UNLOCK) ? hidx : node_ext[NW-1:0];

	assign ln = local_next_q[aidx];
	assign ls = local_serving_q[aidx];
	assign cp = cohort_pass_q[aidx];
	assign bl = batch_left_q[aidx];

	// Operation decode: next values for the selected node and the global lock
	tick_t                       ln_d;
	tick_t                       ls_d;
	logic                        cp_d;
	logic [BW-1:0]               bl_d;
	tick_t                       gn_d;
	tick_t                       gs_d;
	logic [ctlm_pkg::NodeW-1:0]  hn_d;
	ctlm_pkg::status_t           st_d;
	tick_t                       tko_d;
	tick_t                       ls_inc;

	assign ls_inc = ls + tick_t'(1);

	always_comb begin
		ln_d  = ln;
		ls_d  = ls;
		cp_d  = cp;
		bl_d  = bl;
		gn_d  = global_next_q;
		gs_d  = global_serving_q;
		hn_d  = holder_node_q;
		st_d  = ctlm_pkg::ST_BUSY;
		tko_d = '0;
		if (opcode_s1 == ctlm_pkg::OP_UNLOCK) begin
			// hand over within the node while the budget lasts
			if ((ln != ls_inc) && (bl != '0)) begin
				bl_d = bl - BW'(1);
				cp_d = 1'b1;
				ls_d = ls_inc;
				st_d = ctlm_pkg::ST_PASSED;
			end else begin
				if (ln != ls_inc) begin
					bl_d = BW'(batch_limit_q);
				end
				gs_d = global_serving_q + tick_t'(1);
				ls_d = ls_inc;
				st_d = ctlm_pkg::ST_RELEASED;
			end
		end else if (node_ok) begin
			case (opcode_s1)
				ctlm_pkg::OP_TAKE_LOCAL: begin
					tko_d = ln;
					ln_d  = ln + tick_t'(1);
					st_d  = ctlm_pkg::ST_ISSUED;
				end
				ctlm_pkg::OP_POLL_LOCAL: begin
					if (ls != tk) begin
						st_d = ctlm_pkg::ST_WAIT;
					end else if (cp) begin
						cp_d = 1'b0;
						st_d = ctlm_pkg::ST_ACQUIRED;
					end else begin
						st_d = ctlm_pkg::ST_NEED_GLOBAL;
					end
				end
				ctlm_pkg::OP_TAKE_GLOBAL: begin
					tko_d = global_next_q;
					gn_d  = global_next_q + tick_t'(1);
					st_d  = ctlm_pkg::ST_ISSUED;
				end
				ctlm_pkg::OP_POLL_GLOBAL: begin
					if (global_serving_q != tk) begin
						st_d = ctlm_pkg::ST_WAIT;
					end else begin
						hn_d = node_s1;
						st_d = ctlm_pkg::ST_ACQUIRED;
					end
				end
				ctlm_pkg::OP_TRYLOCK: begin
					if (ln == ls) begin
						ln_d = ln + tick_t'(1);
						if (cp) begin
							cp_d = 1'b0;
							st_d = ctlm_pkg::ST_ACQUIRED;
						end else if (global_next_q != global_serving_q) begin
							// global lock taken: give the local ticket back
							ls_d = ls_inc;
							st_d = ctlm_pkg::ST_BUSY;
						end else begin
							gn_d = global_next_q + tick_t'(1);
							hn_d = node_s1;
							st_d = ctlm_pkg::ST_ACQUIRED;
						end
					end
				end
				default: begin
					st_d = ctlm_pkg::ST_BUSY;
				end
			endcase
		end
	end

	// State write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				local_next_q[i]    <= '0;
				local_serving_q[i] <= '0;
				cohort_pass_q[i]   <= 1'b0;
				batch_left_q[i]    <= '0;
			end
			global_next_q    <= '0;
			global_serving_q <= '0;
			holder_node_q    <= '0;
		end else if (fire) begin
			local_next_q[aidx]    <= ln_d;
			local_serving_q[aidx] <= ls_d;
			cohort_pass_q[aidx]   <= cp_d;
			batch_left_q[aidx]    <= bl_d;
			global_next_q         <= gn_d;
			global_serving_q      <= gs_d;
			holder_node_q         <= hn_d;
		end
	end

	// Result register
	logic [TB+7:0] tko_ext;
	assign tko_ext = {8'd0, tko_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= st_d;
			ticket_out_q <= tko_ext[TW-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.ticket_out = ticket_out_q;

endmodule

FILE: sv/ctlm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlm_port_checker: port-level checks for the cohort ticket lock manager
// Watches the response channel and the configuration port over time.
// ----------------------------------------------------------------------------
module ctlm_port_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [ctlm_pkg::StatusW-1:0]  rsp_status,
	input  logic [ctlm_pkg::TicketW-1:0]  rsp_ticket_out,
	input  logic                          pready
);

	// a stalled result holds its item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_ticket_out))
		else $error("ctlm: stalled result changed");

	// only the defined status codes are ever shown
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status <= ctlm_pkg::ST_RELEASED))
		else $error("ctlm: undefined status code");

	// a ticket is returned only with an issued status
	a_ticket_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ctlm_pkg::ST_ISSUED) |-> (rsp_ticket_out == '0))
		else $error("ctlm: ticket on non-issue result");

	// the register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("ctlm: pready low");

endmodule

bind cohort_ticket_lock_manager_top ctlm_port_checker u_ctlm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_ticket_out (rsp.ticket_out),
	.pready         (pready)
);
